>>> src/bswo_pkg.sv
// ----------------------------------------------------------------------------
// bswo_pkg
// Shared sizes, command and status codes, and ring index helper for the
// bounded stack with oldest-entry drop.
// ----------------------------------------------------------------------------
package bswo_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 8;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int SW         = CW + 1;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_FORCE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

    // Fold a sum below twice DEPTH back into the ring.
    function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] sum);
        logic [SW-1:0] folded;
        folded = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
        return folded[AW-1:0];
    endfunction

endpackage

>>> src/bswo_ram.sv
// ----------------------------------------------------------------------------
// bswo_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bswo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bounded_stack_with_overwrite_core.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_overwrite_core
// Result strobe o_valid is registered, high in the cycle after acceptance.
// Throughput: one transaction per cycle; busy stays low, since each command
// touches one RAM entry and the read of a pop never meets a write in the same
// cycle. Result ports are valid for exactly one cycle; the receiver cannot stall.
// Reset: synchronous active-low i_rst_n empties the stack (count and bottom
// pointer to zero); RAM contents are left as they are and never read unwritten.
// ----------------------------------------------------------------------------
module bounded_stack_with_overwrite_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_cmd,
    input  logic [bswo_pkg::DATA_WIDTH-1:0]    i_data_in,
    output logic                               o_valid,
    output logic [bswo_pkg::DATA_WIDTH-1:0]    o_data_out,
    output logic [1:0]                         o_status,
    output logic                               o_dropped,
    output logic [bswo_pkg::CW-1:0]            o_fill_count,
    output logic                               o_is_empty,
    output logic                               o_is_full
);
    import bswo_pkg::*;

    logic [AW-1:0]         r_bottom, n_bottom;
    logic [CW-1:0]         r_count,  n_count;
    logic                  r_valid;
    logic                  r_pop,    n_pop;
    t_status               r_status, n_status;
    logic                  r_dropped, n_dropped;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] rdata;
    logic [SW-1:0]         bot_s;
    logic [SW-1:0]         cnt_s;
    logic                  full;
    logic                  accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign bot_s  = SW'(r_bottom);
    assign cnt_s  = SW'(r_count);
    assign full   = (cnt_s == DEPTH_S);

    always_comb begin
        n_bottom  = r_bottom;
        n_count   = r_count;
        n_pop     = 1'b0;
        n_status  = ST_OK;
        n_dropped = 1'b0;
        we        = 1'b0;
        waddr     = ring_wrap(bot_s + cnt_s);
        raddr     = ring_wrap(bot_s + cnt_s - SW'(1));
        if (accept) begin
            unique case (i_cmd)
                CMD_PUSH, CMD_FORCE: begin
                    if (!full) begin
                        we      = 1'b1;
                        n_count = r_count + CW'(1);
                    end else if (i_cmd == CMD_FORCE) begin
                        we        = 1'b1;
                        waddr     = r_bottom;
                        n_bottom  = ring_wrap(bot_s + SW'(1));
                        n_dropped = 1'b1;
                    end else begin
                        n_status = ST_OVERFLOW;
                    end
                end
                CMD_POP: begin
                    if (r_count != '0) begin
                        n_count = r_count - CW'(1);
                        n_pop   = 1'b1;
                    end else begin
                        n_status = ST_UNDERFLOW;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    bswo_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_data_in),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bottom  <= '0;
            r_count   <= '0;
            r_valid   <= 1'b0;
            r_pop     <= 1'b0;
            r_status  <= ST_OK;
            r_dropped <= 1'b0;
        end else begin
            r_bottom  <= n_bottom;
            r_count   <= n_count;
            r_valid   <= accept;
            r_pop     <= n_pop;
            r_status  <= n_status;
            r_dropped <= n_dropped;
        end
    end

    assign o_valid      = r_valid;
    assign o_data_out   = r_pop ? rdata : '0;
    assign o_status     = r_status;
    assign o_dropped    = r_dropped;
    assign o_fill_count = r_count;
    assign o_is_empty   = (r_count == '0);
    assign o_is_full    = (SW'(r_count) == DEPTH_S);

endmodule

>>> tb/tb_bounded_stack_with_overwrite_core.sv
// ----------------------------------------------------------------------------
// tb_bounded_stack_with_overwrite_core
// Self-checking bench for the bounded stack with oldest-entry drop. A shadow
// ring of entries predicts every result strobe from the commands the core takes.
// A directed pass covers empty and full edges, overflow, forced drop and the
// unused command. Random bursts follow, biased to filling, draining, forced
// pushing or to none, under several sender idle rates with drains between them.
// ----------------------------------------------------------------------------
module tb_bounded_stack_with_overwrite_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bswo_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [DATA_WIDTH-1:0] word;
        t_status               status;
        logic                  dropped;
        logic [CW-1:0]         fill;
        logic                  empty;
        logic                  full;
    } t_stack_outcome;

    class t_lifo_scoreboard;
        logic [DATA_WIDTH-1:0] slots [DEPTH];
        int                    base_idx;
        int                    depth_used;
        t_stack_outcome        pending_outcomes[$];
        int                    errors;

        function new();
            base_idx   = 0;
            depth_used = 0;
            errors     = 0;
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        function void apply_command(logic [1:0] c, logic [DATA_WIDTH-1:0] d);
            t_stack_outcome o;
            o.word    = '0;
            o.status  = ST_OK;
            o.dropped = 1'b0;
            if (c == CMD_PUSH || c == CMD_FORCE) begin
                if (depth_used < DEPTH) begin
                    slots[(base_idx + depth_used) % DEPTH] = d;
                    depth_used++;
                end else if (c == CMD_FORCE) begin
                    slots[base_idx] = d;
                    base_idx        = (base_idx + 1) % DEPTH;
                    o.dropped       = 1'b1;
                end else begin
                    o.status = ST_OVERFLOW;
                end
            end else if (c == CMD_POP) begin
                if (depth_used > 0) begin
                    depth_used--;
                    o.word = slots[(base_idx + depth_used) % DEPTH];
                end else begin
                    o.status = ST_UNDERFLOW;
                end
            end
            o.fill  = CW'(depth_used);
            o.empty = (depth_used == 0);
            o.full  = (depth_used == DEPTH);
            pending_outcomes.push_back(o);
        endfunction

        function void compare_field(string field, longint unsigned exp_v,
                                    logic [15:0] act_v);
            if (act_v !== 16'(exp_v)) begin
                $error("%s: expected %0d, got %0d", field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_outcome(logic [DATA_WIDTH-1:0] word, logic [1:0] status,
                                    logic dropped, logic [CW-1:0] fill,
                                    logic empty, logic full);
            t_stack_outcome o;
            if (pending_outcomes.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                errors++;
                return;
            end
            o = pending_outcomes.pop_front();
            compare_field("data_out",   o.word,    16'(word));
            compare_field("status",     o.status,  16'(status));
            compare_field("dropped",    o.dropped, 16'(dropped));
            compare_field("fill_count", o.fill,    16'(fill));
            compare_field("is_empty",   o.empty,   16'(empty));
            compare_field("is_full",    o.full,    16'(full));
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic [1:0]            i_cmd       = CMD_PUSH;
    logic [DATA_WIDTH-1:0] i_data_in   = '0;
    logic                  busy;
    logic                  o_valid;
    logic [DATA_WIDTH-1:0] o_data_out;
    logic [1:0]            o_status;
    logic                  o_dropped;
    logic [CW-1:0]         o_fill_count;
    logic                  o_is_empty;
    logic                  o_is_full;

    t_lifo_scoreboard board;

    bounded_stack_with_overwrite_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_data_in    (i_data_in),
        .o_valid      (o_valid),
        .o_data_out   (o_data_out),
        .o_status     (o_status),
        .o_dropped    (o_dropped),
        .o_fill_count (o_fill_count),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && board != null) begin
            if (o_valid) begin
                board.check_outcome(o_data_out, o_status, o_dropped, o_fill_count,
                                    o_is_empty, o_is_full);
            end
            if (start && !busy) begin
                board.apply_command(i_cmd, i_data_in);
            end
        end
    end

    task automatic send_txn(input logic [1:0] c, input logic [DATA_WIDTH-1:0] d,
                            input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_cmd     <= c;
        i_data_in <= d;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return DATA_WIDTH'($urandom());
    endfunction

    function automatic logic [1:0] pick_cmd(input int mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            0: begin
                if (r < 60) return CMD_PUSH;
                if (r < 80) return CMD_FORCE;
                if (r < 95) return CMD_POP;
                return CMD_SPARE;
            end
            1: begin
                if (r < 70) return CMD_POP;
                if (r < 85) return CMD_PUSH;
                if (r < 95) return CMD_FORCE;
                return CMD_SPARE;
            end
            2: begin
                if (r < 60) return CMD_FORCE;
                if (r < 85) return CMD_POP;
                if (r < 95) return CMD_PUSH;
                return CMD_SPARE;
            end
            default: return 2'($urandom_range(3));
        endcase
    endfunction

    initial begin
        #5ms;
        $display("tb_bounded_stack_with_overwrite_core: errors");
        $finish;
    end

    initial begin
        int idle_plan [6];
        int remaining;
        int mode;
        int burst;
        idle_plan = '{0, 67, 19, 0, 67, 19};
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_txn(CMD_POP, 8'h5A, 0);
        send_txn(CMD_SPARE, 8'hFF, 0);
        for (int k = 0; k < DEPTH; k++) begin
            send_txn(CMD_PUSH, (k % 3 == 0) ? 8'h00 : (k % 3 == 1) ? 8'hFF : pick_word(), 0);
        end
        send_txn(CMD_PUSH, 8'hA5, 0);
        send_txn(CMD_FORCE, 8'hFF, 0);
        send_txn(CMD_FORCE, 8'h00, 0);
        send_txn(CMD_SPARE, 8'h3C, 0);
        send_txn(CMD_POP, 8'h00, 0);
        send_txn(CMD_POP, 8'hFF, 0);
        drain_results();

        foreach (idle_plan[p]) begin
            remaining = 210;
            while (remaining > 0) begin
                mode  = $urandom_range(3);
                burst = $urandom_range(6, 40);
                for (int k = 0; k < burst && remaining > 0; k++) begin
                    send_txn(pick_cmd(mode), pick_word(), idle_plan[p]);
                    remaining--;
                end
            end
            drain_results();
        end

        repeat (4) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb_bounded_stack_with_overwrite_core: clean");
        end else begin
            $display("tb_bounded_stack_with_overwrite_core: errors");
        end
        $finish;
    end

endmodule
